### sv/md5_message_digest_macros.svh
// Assertion helpers for the digest block
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define MD5_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Check that a condition implies a consequence in the next cycle
`define MD5_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### sv/md5_pkg.sv
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_beat_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Rotate amount per round
  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word index per round
  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
      2'd3: g = 4'(i[3:0] * 4'd7);
      default: g = 4'd0;
    endcase
    return g;
  endfunction

endpackage

### sv/md5_fifo.sv
module md5_fifo #(
  parameter int Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  md5_pkg::in_beat_t  wdata_i,
  output logic               full_o,
  input  logic               rd_i,
  output md5_pkg::in_beat_t  rdata_o,
  output logic               empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  md5_pkg::in_beat_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  // Hold beats between the input port and engine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) begin
        wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (rd_i && !empty_o) begin
        rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(wr_i && !full_o) - (AW+1)'(rd_i && !empty_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

### sv/md5_engine.sv
module md5_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  md5_pkg::in_beat_t   beat_i,
  input  logic                beat_valid_i,
  output logic                beat_take_o,
  output md5_pkg::out_beat_t  res_o,
  output logic                res_valid_o,
  input  logic                res_take_i,
  output logic                busy_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_LEN  = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [31:0] blk_q [16];
  logic [31:0] ch_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [63:0] cnt_q;
  logic [5:0]  rnd_q;
  logic [5:0]  pp_q;
  logic        fin_q;   // end of message seen; padding pending, in progress or done
  logic        lenb_q;  // block being compressed carries the length
  logic [1:0]  oi_q;

  logic [5:0]  pos;
  logic [31:0] f, sum, rot, kk;
  logic [4:0]  sh;

  assign pos = cnt_q[8:3];
  assign beat_take_o = (st_q == S_IDLE) && beat_valid_i;
  assign busy_o = (st_q != S_IDLE);

  // Round function
  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: f = d_q ^ (b_q & (c_q ^ d_q));
      2'd1: f = c_q ^ (d_q & (b_q ^ c_q));
      2'd2: f = b_q ^ c_q ^ d_q;
      2'd3: f = c_q ^ (b_q | ~d_q);
      default: f = '0;
    endcase
    kk  = md5_pkg::round_k(rnd_q);
    sh  = md5_pkg::rot_amt(rnd_q);
    sum = a_q + f + kk + blk_q[md5_pkg::msg_idx(rnd_q)];
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  assign res_valid_o = (st_q == S_OUT);
  assign res_o.digest_word = ch_q[oi_q];
  assign res_o.word_index  = oi_q;
  assign res_o.last_word   = (oi_q == 2'd3);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (beat_valid_i) begin
        if (beat_i.byte_valid && pos == 6'd63) st_d = S_RND;
        else if (beat_i.end_of_message) st_d = S_PAD;
      end
      S_PAD:   if (pp_q == 6'd63) st_d = S_RND;
      S_RND:   if (rnd_q == 6'd63) begin
        if (fin_q && !lenb_q) st_d = (pp_q == 6'd63 && pos >= 6'd56) ? S_LEN : S_PAD;
        else if (lenb_q) st_d = S_OUT;
        else st_d = fin_q ? S_PAD : S_IDLE;
      end
      S_LEN:   st_d = S_RND;
      S_OUT:   if (res_take_i && oi_q == 2'd3) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // Advance control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      rnd_q  <= '0;
      pp_q   <= '0;
      fin_q  <= 1'b0;
      lenb_q <= 1'b0;
      oi_q   <= '0;
      ch_q[0] <= md5_pkg::IV_A;
      ch_q[1] <= md5_pkg::IV_B;
      ch_q[2] <= md5_pkg::IV_C;
      ch_q[3] <= md5_pkg::IV_D;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        S_IDLE: if (beat_valid_i) begin
          if (beat_i.byte_valid) cnt_q <= cnt_q + 64'd8;
          fin_q  <= beat_i.end_of_message;
          lenb_q <= 1'b0;
          rnd_q  <= '0;
          pp_q   <= beat_i.byte_valid ? pos + 6'd1 : pos;
        end
        S_PAD: begin
          if (pp_q == 6'd63) begin
            rnd_q  <= '0;
            lenb_q <= (pos < 6'd56);
          end else begin
            pp_q <= pp_q + 6'd1;
          end
        end
        S_LEN: begin
          rnd_q  <= '0;
          lenb_q <= 1'b1;
        end
        S_RND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            ch_q[0] <= ch_q[0] + d_q;
            ch_q[1] <= ch_q[1] + b_q + rot;
            ch_q[2] <= ch_q[2] + b_q;
            ch_q[3] <= ch_q[3] + c_q;
            if (fin_q && !lenb_q && !(pp_q == 6'd63 && pos >= 6'd56)) begin
              // Byte filled block on an end beat: pad from the start
              pp_q <= '0;
            end
          end
        end
        S_OUT: if (res_take_i) begin
          oi_q <= oi_q + 2'd1;
          if (oi_q == 2'd3) begin
            ch_q[0] <= md5_pkg::IV_A;
            ch_q[1] <= md5_pkg::IV_B;
            ch_q[2] <= md5_pkg::IV_C;
            ch_q[3] <= md5_pkg::IV_D;
            cnt_q   <= '0;
            fin_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working variables and block words
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && beat_valid_i && beat_i.byte_valid) begin
      blk_q[pos[5:2]][pos[1:0]*8 +: 8] <= beat_i.data_byte;
    end
    if (st_q == S_PAD) begin
      if (pp_q == 6'd63 && pos < 6'd56) begin
        blk_q[14] <= cnt_q[31:0];
        blk_q[15] <= cnt_q[63:32];
      end else begin
        blk_q[pp_q[5:2]][pp_q[1:0]*8 +: 8] <= (pp_q == pos) ? md5_pkg::PAD_BYTE : 8'h00;
      end
    end
    if (st_q == S_LEN) begin
      for (int j = 0; j < 14; j++) blk_q[j] <= '0;
      blk_q[14] <= cnt_q[31:0];
      blk_q[15] <= cnt_q[63:32];
    end
    if (st_d == S_RND && st_q != S_RND) begin
      a_q <= ch_q[0]; b_q <= ch_q[1]; c_q <= ch_q[2]; d_q <= ch_q[3];
    end else if (st_q == S_RND) begin
      a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
    end
  end

endmodule

### sv/md5_message_digest.sv
// Channel | Handshake     | Beat
// input   | push_i/full_o | md5_pkg::in_beat_t
// result  | pop_i/empty_o | md5_pkg::out_beat_t
// A plain byte is stored in the block; a block-filling byte is stored and then runs 64 rounds.
// An end beat is followed by padding from its position to the block end (a whole block
// of padding after a block-filling byte, whose 64 rounds come first), 64 rounds, and a
// length-only block of 64 rounds when the length does not fit, before 4 result beats.
// Reset loads the initial vector at once; no clearing pass.
// The input queue holds QueueDepth beats while the engine compresses or waits on pop.
`include "md5_message_digest_macros.svh"
module md5_message_digest #(
  parameter int QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  md5_pkg::in_beat_t  in_i,
  output logic               full_o,
  input  logic               pop_i,
  output md5_pkg::out_beat_t out_o,
  output logic               empty_o
);

  md5_pkg::in_beat_t q_beat;
  logic q_empty, take, res_valid, busy;

  md5_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .wr_i(push_i), .wdata_i(in_i), .full_o,
    .rd_i(take), .rdata_o(q_beat), .empty_o(q_empty)
  );

  md5_engine u_engine (
    .clk_i, .rst_ni, .beat_i(q_beat), .beat_valid_i(!q_empty),
    .beat_take_o(take), .res_o(out_o), .res_valid_o(res_valid),
    .res_take_i(pop_i), .busy_o(busy)
  );

  assign empty_o = !res_valid;

  `MD5_ASSERT_IMP(a_take_idle, clk_i, rst_ni, take, !busy && !q_empty)
  `MD5_ASSERT_IMP(a_res_busy, clk_i, rst_ni, !empty_o, busy)
  `MD5_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, !empty_o && !pop_i, !empty_o && $stable(out_o))

endmodule
